>>> src/cdps_pkg.sv
// Shared types, constants and digit helpers for the clock display page sequencer.
// Used by cdps_fmt, cdps_ctrl and clock_display_page_sequencer; no dependencies.
package cdps_pkg;

  localparam int DIGIT_COUNT = 8;
  localparam int CNT_W       = 16;
  localparam int RTC_W       = 7;
  localparam int CODE_W      = 5;
  localparam int CFG_IDX_W   = 2;

  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [RTC_W-1:0]     rtc_t;
  typedef logic [CODE_W-1:0]    code_t;
  typedef logic [3:0]           bcd_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef code_t [DIGIT_COUNT-1:0] page_t;

  localparam cnt_t ELAPSED_MAX       = 16'hFFFF;
  localparam cnt_t READ_INTERVAL_RST = 16'd1000;
  localparam cnt_t DATE_SHOW_RST     = 16'd1000;
  localparam cnt_t TIME_SHOW_RST     = 16'd5000;
  localparam cnt_t READ_ELAPSED_RST  = READ_INTERVAL_RST - 16'd1;

  localparam cfg_idx_t REG_READ_INTERVAL = 2'd0;
  localparam cfg_idx_t REG_DATE_SHOW     = 2'd1;
  localparam cfg_idx_t REG_TIME_SHOW     = 2'd2;

  localparam code_t CODE_DASH    = 5'd21;
  localparam code_t POINT_OFFSET = 5'd10;
  localparam code_t CENTURY_HI   = 5'd2;
  localparam code_t CENTURY_LO   = 5'd0;

  localparam rtc_t YEAR_MAX   = 7'd99;
  localparam rtc_t MONTH_MAX  = 7'd12;
  localparam rtc_t DAY_MAX    = 7'd31;
  localparam rtc_t HOUR_MAX   = 7'd23;
  localparam rtc_t MINSEC_MAX = 7'd59;

  typedef struct packed {
    rtc_t year;
    rtc_t month;
    rtc_t day;
    rtc_t hour;
    rtc_t minute;
    rtc_t second;
    logic read_ok;
    logic bus_busy;
  } item_t;

  typedef struct packed {
    cnt_t read_interval;
    cnt_t date_show;
    cnt_t time_show;
  } cfg_t;

  typedef struct packed {
    logic  shown;
    logic  show_time;
    page_t digits;
  } result_t;

  typedef struct packed {
    logic clock_valid;
  } status_t;

  // Divide by ten through a reciprocal multiply; exact for all 7-bit values.
  function automatic bcd_t tens_of(rtc_t v);
    logic [14:0] p;
    p = 15'(v) * 15'd205;
    return p[14:11];
  endfunction

  function automatic bcd_t ones_of(rtc_t v);
    logic [6:0] t;
    t = 7'(tens_of(v)) * 7'd10;
    return 4'(v - t);
  endfunction

  function automatic logic sample_valid(item_t it);
    return (it.year <= YEAR_MAX) &&
           (it.month != '0) && (it.month <= MONTH_MAX) &&
           (it.day != '0) && (it.day <= DAY_MAX) &&
           (it.hour <= HOUR_MAX) &&
           (it.minute <= MINSEC_MAX) && (it.second <= MINSEC_MAX);
  endfunction

endpackage

>>> src/clock_display_page_sequencer.sv
// Clock display page sequencer: top level with config registers, input and result stages.
// Depends on cdps_pkg and cdps_ctrl.
//
// Usage:
//   Each word on the in_ channel is one millisecond tick with an RTC reading and
//   the read_ok / bus_busy flags. Each word on the out_ channel is the full
//   8-digit display plus the page flag, sent only on ticks that set the display
//   (a valid sample or a page flip). Ticks that set nothing produce no word.
//   Registers 0..2 (read interval, date show time, time show time) are written
//   through cfg_we / cfg_index / cfg_wdata while the block is idle; index 3 is
//   ignored.
//   Throughput: one tick per cycle while the out_ channel is not stalled. A tick
//   is held in the input register, then processed in one pass into the result
//   register, which drives its word on the out_ channel.
//   Reset (rst_n low, synchronous) loads the register defaults, sets the read
//   counter one short of the interval so the first tick samples, and sends no
//   words until the first valid sample.
//   When out_ready is low, the result register holds its word and the input
//   register can still take one more tick; in_ready drops once both are full.
module clock_display_page_sequencer (
  input  logic                     clk,
  input  logic                     rst_n,

  input  logic                     cfg_we,
  input  cdps_pkg::cfg_idx_t       cfg_index,
  input  cdps_pkg::cnt_t           cfg_wdata,

  input  logic                     in_valid,
  output logic                     in_ready,
  input  cdps_pkg::rtc_t           in_rtc_year,
  input  cdps_pkg::rtc_t           in_rtc_month,
  input  cdps_pkg::rtc_t           in_rtc_day,
  input  cdps_pkg::rtc_t           in_rtc_hour,
  input  cdps_pkg::rtc_t           in_rtc_minute,
  input  cdps_pkg::rtc_t           in_rtc_second,
  input  logic                     in_read_ok,
  input  logic                     in_bus_busy,

  output logic                     out_valid,
  input  logic                     out_ready,
  output cdps_pkg::code_t          out_digit0,
  output cdps_pkg::code_t          out_digit1,
  output cdps_pkg::code_t          out_digit2,
  output cdps_pkg::code_t          out_digit3,
  output cdps_pkg::code_t          out_digit4,
  output cdps_pkg::code_t          out_digit5,
  output cdps_pkg::code_t          out_digit6,
  output cdps_pkg::code_t          out_digit7,
  output logic                     out_showing_time_page
);

  cdps_pkg::cfg_t    cfg_r;
  cdps_pkg::item_t   in_item_r;
  logic              in_valid_r;
  logic              out_valid_r, out_valid_nxt;
  cdps_pkg::page_t   out_digits_r;
  logic              out_show_time_r;

  cdps_pkg::result_t result;
  cdps_pkg::status_t status;
  logic              advance;

  // Process the held tick whenever the result register is free or draining
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.read_interval <= cdps_pkg::READ_INTERVAL_RST;
      cfg_r.date_show     <= cdps_pkg::DATE_SHOW_RST;
      cfg_r.time_show     <= cdps_pkg::TIME_SHOW_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        cdps_pkg::REG_READ_INTERVAL: cfg_r.read_interval <= cfg_wdata;
        cdps_pkg::REG_DATE_SHOW:     cfg_r.date_show     <= cfg_wdata;
        cdps_pkg::REG_TIME_SHOW:     cfg_r.time_show     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r.year     <= in_rtc_year;
      in_item_r.month    <= in_rtc_month;
      in_item_r.day      <= in_rtc_day;
      in_item_r.hour     <= in_rtc_hour;
      in_item_r.minute   <= in_rtc_minute;
      in_item_r.second   <= in_rtc_second;
      in_item_r.read_ok  <= in_read_ok;
      in_item_r.bus_busy <= in_bus_busy;
    end
  end

  cdps_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (in_item_r),
    .cfg     (cfg_r),
    .result  (result),
    .status  (status)
  );

  always_comb begin
    if (advance && result.shown) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.shown) begin
      out_digits_r    <= result.digits;
      out_show_time_r <= result.show_time;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_digit0            = out_digits_r[0];
  assign out_digit1            = out_digits_r[1];
  assign out_digit2            = out_digits_r[2];
  assign out_digit3            = out_digits_r[3];
  assign out_digit4            = out_digits_r[4];
  assign out_digit5            = out_digits_r[5];
  assign out_digit6            = out_digits_r[6];
  assign out_digit7            = out_digits_r[7];
  assign out_showing_time_page = out_show_time_r;

  // No word goes out before the first valid sample
  a_out_needs_clock: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> status.clock_valid)
    else $error("result sent before clock became valid");

  // A stalled result and a held tick together must block the input
  a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && out_valid_r && !out_ready) |-> !in_ready)
    else $error("input accepted while both stages are full");

  // Date page always opens with the century digits
  a_date_page_century: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_show_time_r) |->
      (out_digits_r[0] == cdps_pkg::CENTURY_HI && out_digits_r[1] == cdps_pkg::CENTURY_LO))
    else $error("date page without century prefix");

  // Time page carries dashes between fields
  a_time_page_dash: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_show_time_r) |->
      (out_digits_r[2] == cdps_pkg::CODE_DASH && out_digits_r[5] == cdps_pkg::CODE_DASH))
    else $error("time page without dashes");

endmodule

>>> src/cdps_fmt.sv
// Builds the date page (20YY.MM.DD.) and time page (HH-MM-SS) digit codes from one reading.
// Depends on cdps_pkg.
module cdps_fmt (
  input  cdps_pkg::item_t item,
  output cdps_pkg::page_t date_codes,
  output cdps_pkg::page_t time_codes
);

  always_comb begin
    date_codes[0] = cdps_pkg::CENTURY_HI;
    date_codes[1] = cdps_pkg::CENTURY_LO;
    date_codes[2] = 5'(cdps_pkg::tens_of(item.year));
    date_codes[3] = cdps_pkg::POINT_OFFSET + 5'(cdps_pkg::ones_of(item.year));
    date_codes[4] = 5'(cdps_pkg::tens_of(item.month));
    date_codes[5] = cdps_pkg::POINT_OFFSET + 5'(cdps_pkg::ones_of(item.month));
    date_codes[6] = 5'(cdps_pkg::tens_of(item.day));
    date_codes[7] = cdps_pkg::POINT_OFFSET + 5'(cdps_pkg::ones_of(item.day));

    time_codes[0] = 5'(cdps_pkg::tens_of(item.hour));
    time_codes[1] = 5'(cdps_pkg::ones_of(item.hour));
    time_codes[2] = cdps_pkg::CODE_DASH;
    time_codes[3] = 5'(cdps_pkg::tens_of(item.minute));
    time_codes[4] = 5'(cdps_pkg::ones_of(item.minute));
    time_codes[5] = cdps_pkg::CODE_DASH;
    time_codes[6] = 5'(cdps_pkg::tens_of(item.second));
    time_codes[7] = 5'(cdps_pkg::ones_of(item.second));
  end

endmodule

>>> src/cdps_ctrl.sv
// Tick sequencer: elapsed counters, sampling, page storage and page alternation.
// Depends on cdps_pkg and cdps_fmt.
module cdps_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  cdps_pkg::item_t     item,
  input  cdps_pkg::cfg_t      cfg,
  output cdps_pkg::result_t   result,
  output cdps_pkg::status_t   status
);

  cdps_pkg::cnt_t  read_elapsed_r, read_elapsed_nxt;
  cdps_pkg::cnt_t  page_elapsed_r, page_elapsed_nxt;
  logic            time_page_r, time_page_nxt;
  logic            clock_valid_r, clock_valid_nxt;
  cdps_pkg::page_t date_r, date_nxt;
  cdps_pkg::page_t time_r, time_nxt;

  cdps_pkg::page_t fmt_date;
  cdps_pkg::page_t fmt_time;

  cdps_pkg::cnt_t  read_inc;
  cdps_pkg::cnt_t  page_inc;
  cdps_pkg::cnt_t  page_limit;
  logic            sample;
  logic            good;
  logic            shown;

  cdps_fmt u_fmt (
    .item       (item),
    .date_codes (fmt_date),
    .time_codes (fmt_time)
  );

  always_comb begin
    read_inc = (read_elapsed_r == cdps_pkg::ELAPSED_MAX) ? read_elapsed_r
                                                         : read_elapsed_r + 16'd1;
    page_inc = (page_elapsed_r == cdps_pkg::ELAPSED_MAX) ? page_elapsed_r
                                                         : page_elapsed_r + 16'd1;

    sample = (read_inc >= cfg.read_interval);
    good   = sample && !item.bus_busy && item.read_ok && cdps_pkg::sample_valid(item);

    read_elapsed_nxt = sample ? '0 : read_inc;
    page_elapsed_nxt = page_inc;
    time_page_nxt    = time_page_r;
    clock_valid_nxt  = clock_valid_r;
    date_nxt         = date_r;
    time_nxt         = time_r;
    shown            = good;

    if (good) begin
      date_nxt = fmt_date;
      time_nxt = fmt_time;
      // First valid sample starts on the date page
      if (!clock_valid_r) begin
        clock_valid_nxt  = 1'b1;
        time_page_nxt    = 1'b0;
        page_elapsed_nxt = '0;
      end
    end

    page_limit = time_page_nxt ? cfg.time_show : cfg.date_show;
    if (clock_valid_nxt && (page_elapsed_nxt >= page_limit)) begin
      time_page_nxt    = !time_page_nxt;
      page_elapsed_nxt = '0;
      shown            = 1'b1;
    end

    result.shown     = shown;
    result.show_time = time_page_nxt;
    result.digits    = time_page_nxt ? time_nxt : date_nxt;

    status.clock_valid = clock_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      read_elapsed_r <= cdps_pkg::READ_ELAPSED_RST;
      page_elapsed_r <= '0;
      time_page_r    <= 1'b0;
      clock_valid_r  <= 1'b0;
    end else if (advance) begin
      read_elapsed_r <= read_elapsed_nxt;
      page_elapsed_r <= page_elapsed_nxt;
      time_page_r    <= time_page_nxt;
      clock_valid_r  <= clock_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      date_r <= date_nxt;
      time_r <= time_nxt;
    end
  end

endmodule
